/* rtl/assert_macros.svh */
// Assertion shorthands used by the checker of this project.
// Both macros sample on clk and stay quiet while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent
`define STSK_ASSERT_NOW(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("stsk check failed in the same cycle");

// Consequent must hold in the cycle after the antecedent
`define STSK_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("stsk check failed one cycle later");

`endif

/* rtl/stsk_pkg.sv */
package stsk_pkg;

  // Field widths
  localparam int IDX_W     = 6;
  localparam int SIZE_W    = 6;
  localparam int VALUE_W   = 64;
  localparam int IN_DATA_W = 16;

  localparam logic [VALUE_W-1:0] VALUE_ALL_ONES = '1;
  localparam logic [VALUE_W-1:0] VALUE_ZERO     = '0;

  // Reset value of the table size register
  localparam logic [SIZE_W-1:0] TABLE_SIZE_RESET = 6'd32;

  // Request kind
  typedef enum logic {
    MODE_BUILD = 1'b0,
    MODE_QUERY = 1'b1
  } stsk_mode_t;

  // Result status
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_RANGE     = 2'd1,
    ST_NOT_BUILT = 2'd2,
    ST_SAT       = 2'd3
  } stsk_status_t;

  // One table entry: value and saturation mark
  typedef struct packed {
    logic               sat;
    logic [VALUE_W-1:0] value;
  } stsk_entry_t;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_BUILD_RD,
    S_BUILD_MUL,
    S_BUILD_ADD,
    S_QUERY_RD,
    S_QUERY_DATA,
    S_FINISH
  } stsk_state_t;

endpackage

/* rtl/stsk_table_mem.sv */
module stsk_table_mem #(
  parameter int AW = 10
) (
  input  logic                clk,
  input  logic                wr_en,
  input  logic [AW-1:0]       wr_addr,
  input  stsk_pkg::stsk_entry_t wr_data,
  input  logic                rd_en,
  input  logic [AW-1:0]       rd_addr,
  output stsk_pkg::stsk_entry_t rd_data
);
  import stsk_pkg::*;

  stsk_entry_t mem [2**AW];
  stsk_entry_t rd_data_r;

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* rtl/stsk_recur_unit.sv */
module stsk_recur_unit #(
  parameter int FW = 6
) (
  input  logic                  clk,
  input  logic                  mul_en,
  input  stsk_pkg::stsk_entry_t up,
  input  logic [FW-1:0]         factor,
  input  stsk_pkg::stsk_entry_t ul,
  output stsk_pkg::stsk_entry_t sum
);
  import stsk_pkg::*;

  logic [VALUE_W+FW-1:0] prod_full;
  logic [VALUE_W-1:0]    prod_r;
  logic                  prod_sat_r;
  logic [VALUE_W:0]      add_full;
  logic                  sum_sat;

  // Multiply the upper entry by the column factor
  assign prod_full = (VALUE_W+FW)'(up.value) * (VALUE_W+FW)'(factor);

  // Hold the product for the add step
  always_ff @(posedge clk) begin
    if (mul_en) begin
      prod_r     <= prod_full[VALUE_W-1:0];
      prod_sat_r <= up.sat | (|prod_full[VALUE_W+FW-1:VALUE_W]);
    end
  end

  // Saturating add of the upper-left entry
  assign add_full  = {1'b0, ul.value} + {1'b0, prod_r};
  assign sum_sat   = prod_sat_r | ul.sat | add_full[VALUE_W];
  assign sum.sat   = sum_sat;
  assign sum.value = sum_sat ? VALUE_ALL_ONES : add_full[VALUE_W-1:0];

endmodule

/* rtl/stirling_second_kind_table_unit.sv */
// Query: S_QUERY_RD reads the table, S_QUERY_DATA takes the entry, S_FINISH hands it
// over (straight to S_FINISH when not built or out of range). Build of size n: n*n
// entries, each through S_BUILD_RD/MUL/ADD, the shared multiply/add unit and the single
// table read port. One request at a time. Reset (rst_n low, synchronous): table
// not built, size register back to 32, output empty. Table contents are not cleared.
module stirling_second_kind_table_unit #(
  parameter int MAX_SIZE = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // configuration: table_size
  input  logic                          cfg_wr_en,
  input  logic [stsk_pkg::SIZE_W-1:0]   cfg_wr_data,
  // request channel
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [stsk_pkg::IN_DATA_W-1:0] in_tdata,  // [5:0] row_index, [11:6] column_index
  input  logic                          in_tuser,  // [0] mode
  // result channel
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [stsk_pkg::VALUE_W-1:0]  out_tdata, // [63:0] number_value
  output logic [1:0]                    out_tuser  // [1:0] status
);
  import stsk_pkg::*;

  localparam int IDXW = $clog2(MAX_SIZE);
  localparam int SZW  = $clog2(MAX_SIZE + 1);
  localparam int AW   = 2 * IDXW;
  localparam int CMPW = (SZW > IDX_W) ? SZW : IDX_W;

  stsk_state_t        state_r, state_nxt;
  logic [SIZE_W-1:0]  table_size_r;
  logic [SZW-1:0]     size_r, size_nxt;
  logic [SZW-1:0]     built_size_r, built_size_nxt;
  logic               ready_r, ready_nxt;
  logic [IDXW-1:0]    row_r, row_nxt;
  logic [IDXW-1:0]    col_r, col_nxt;
  logic [IDXW-1:0]    q_row_r, q_row_nxt;
  logic [IDXW-1:0]    q_col_r, q_col_nxt;
  stsk_entry_t        ul_r, ul_nxt;
  logic [VALUE_W-1:0] res_value_r, res_value_nxt;
  stsk_status_t       res_status_r, res_status_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [VALUE_W-1:0] out_value_r, out_value_nxt;
  stsk_status_t       out_status_r, out_status_nxt;

  logic               rd_en, wr_en, mul_en;
  logic [AW-1:0]      rd_addr, wr_addr;
  stsk_entry_t        rd_data, wr_data, unit_sum;
  logic [SZW-1:0]     factor;
  logic [SZW-1:0]     size_clamp;
  logic [IDX_W-1:0]   row_in, col_in, row_m1, col_m1;
  logic               in_range;
  logic               last_col, last_row;

  assign row_in = in_tdata[IDX_W-1:0];
  assign col_in = in_tdata[2*IDX_W-1:IDX_W];
  assign row_m1 = row_in - IDX_W'(1);
  assign col_m1 = col_in - IDX_W'(1);

  // Limit the requested size to the table dimension
  assign size_clamp = (CMPW'(table_size_r) > CMPW'(MAX_SIZE)) ? SZW'(MAX_SIZE)
                                                               : SZW'(table_size_r);

  assign in_range = (row_in != '0) && (col_in != '0) &&
                    (CMPW'(row_in) <= CMPW'(built_size_r)) &&
                    (CMPW'(col_in) <= CMPW'(built_size_r));

  assign factor   = SZW'(col_r) + SZW'(1);
  assign last_col = (SZW'(col_r) == (size_r - SZW'(1)));
  assign last_row = (SZW'(row_r) == (size_r - SZW'(1)));

  stsk_table_mem #(.AW(AW)) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  stsk_recur_unit #(.FW(SZW)) u_recur (
    .clk    (clk),
    .mul_en (mul_en),
    .up     (rd_data),
    .factor (factor),
    .ul     (ul_r),
    .sum    (unit_sum)
  );

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      table_size_r <= TABLE_SIZE_RESET;
    end else if (cfg_wr_en) begin
      table_size_r <= cfg_wr_data;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      built_size_r <= '0;
      ready_r      <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      built_size_r <= built_size_nxt;
      ready_r      <= ready_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Counters and payload
  always_ff @(posedge clk) begin
    size_r       <= size_nxt;
    row_r        <= row_nxt;
    col_r        <= col_nxt;
    q_row_r      <= q_row_nxt;
    q_col_r      <= q_col_nxt;
    ul_r         <= ul_nxt;
    res_value_r  <= res_value_nxt;
    res_status_r <= res_status_nxt;
    out_value_r  <= out_value_nxt;
    out_status_r <= out_status_nxt;
  end

  // Sequencer
  always_comb begin
    state_nxt      = state_r;
    size_nxt       = size_r;
    built_size_nxt = built_size_r;
    ready_nxt      = ready_r;
    row_nxt        = row_r;
    col_nxt        = col_r;
    q_row_nxt      = q_row_r;
    q_col_nxt      = q_col_r;
    ul_nxt         = ul_r;
    res_value_nxt  = res_value_r;
    res_status_nxt = res_status_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_value_nxt  = out_value_r;
    out_status_nxt = out_status_r;
    in_tready      = 1'b0;
    rd_en          = 1'b0;
    rd_addr        = {row_r - IDXW'(1), col_r};
    wr_en          = 1'b0;
    wr_addr        = {row_r, col_r};
    wr_data        = unit_sum;
    mul_en         = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          res_value_nxt = VALUE_ZERO;
          if (in_tuser == MODE_BUILD) begin
            size_nxt       = size_clamp;
            row_nxt        = '0;
            col_nxt        = '0;
            res_status_nxt = ST_OK;
            if (size_clamp == '0) begin
              built_size_nxt = '0;
              ready_nxt      = 1'b1;
              state_nxt      = S_FINISH;
            end else begin
              state_nxt = S_BUILD_RD;
            end
          end else if (!ready_r) begin
            res_status_nxt = ST_NOT_BUILT;
            state_nxt      = S_FINISH;
          end else if (!in_range) begin
            res_status_nxt = ST_RANGE;
            state_nxt      = S_FINISH;
          end else begin
            q_row_nxt = row_m1[IDXW-1:0];
            q_col_nxt = col_m1[IDXW-1:0];
            state_nxt = S_QUERY_RD;
          end
        end
      end

      // Fetch the entry above
      S_BUILD_RD: begin
        rd_en     = 1'b1;
        state_nxt = S_BUILD_MUL;
      end

      S_BUILD_MUL: begin
        mul_en    = 1'b1;
        state_nxt = S_BUILD_ADD;
      end

      // Write the entry, keep the upper entry as next upper-left
      S_BUILD_ADD: begin
        wr_en  = 1'b1;
        ul_nxt = rd_data;
        if (col_r == '0 || row_r == col_r) begin
          wr_data = '{sat: 1'b0, value: VALUE_W'(1)};
        end else if (row_r == '0 || col_r > row_r) begin
          wr_data = '{sat: 1'b0, value: VALUE_ZERO};
        end
        if (last_col) begin
          col_nxt = '0;
          if (last_row) begin
            built_size_nxt = size_r;
            ready_nxt      = 1'b1;
            state_nxt      = S_FINISH;
          end else begin
            row_nxt   = row_r + IDXW'(1);
            state_nxt = S_BUILD_RD;
          end
        end else begin
          col_nxt   = col_r + IDXW'(1);
          state_nxt = S_BUILD_RD;
        end
      end

      S_QUERY_RD: begin
        rd_en     = 1'b1;
        rd_addr   = {q_row_r, q_col_r};
        state_nxt = S_QUERY_DATA;
      end

      S_QUERY_DATA: begin
        res_value_nxt  = rd_data.value;
        res_status_nxt = rd_data.sat ? ST_SAT : ST_OK;
        state_nxt      = S_FINISH;
      end

      // Hand the result over once the output register is free
      S_FINISH: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt  = 1'b1;
          out_value_nxt  = res_value_r;
          out_status_nxt = res_status_r;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_value_r;
  assign out_tuser  = out_status_r;

endmodule

/* rtl/stsk_checker.sv */
`include "assert_macros.svh"

module stsk_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_tvalid,
  input logic                         in_tready,
  input logic                         out_tvalid,
  input logic                         out_tready,
  input logic [stsk_pkg::VALUE_W-1:0] out_tdata,
  input logic [1:0]                   out_tuser
);
  import stsk_pkg::*;

  // One request in flight: busy right after a request is taken
  `STSK_ASSERT_NEXT(a_busy_after_req, in_tvalid && in_tready, !in_tready)

  // Saturated results carry all ones
  `STSK_ASSERT_NOW(a_sat_all_ones, out_tvalid && (out_tuser == ST_SAT), out_tdata == VALUE_ALL_ONES)

  // Error results carry zero
  `STSK_ASSERT_NOW(a_err_zero, out_tvalid && (out_tuser == ST_RANGE || out_tuser == ST_NOT_BUILT), out_tdata == VALUE_ZERO)

  // Stalled result holds
  `STSK_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))

endmodule

bind stirling_second_kind_table_unit stsk_checker u_stsk_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
